FILE: rtl/spq_pkg.sv
`default_nettype none
package spq_pkg;

  // Command codes of the input channel.
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // Urgency limits; inserted values are clamped into this range.
  localparam int unsigned UrgW = 3;
  localparam logic [UrgW-1:0] UrgMin = 3'd1;
  localparam logic [UrgW-1:0] UrgMax = 3'd4;

  // Fixed field widths of the ports.
  localparam int unsigned LocPortW = 16;
  localparam int unsigned KindW    = 2;
  localparam int unsigned OccW     = 5;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_REMOVED  = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } spq_status_e;

  // Broadcast control that every cell of the chain sees in the same cycle.
  typedef struct packed {
    logic            ins;
    logic            rem;
    logic [UrgW-1:0] urg;
  } spq_ctrl_t;

endpackage
`default_nettype wire

FILE: rtl/spq_cell.sv
`default_nettype none
module spq_cell #(
  parameter int unsigned LOC_W = 16
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire spq_pkg::spq_ctrl_t        ctrl_i,
  input  wire logic [LOC_W-1:0]          new_loc_i,
  input  wire logic [spq_pkg::KindW-1:0] new_kind_i,
  // Neighbor toward the front of the queue.
  input  wire logic                      left_keep_i,
  input  wire logic                      left_valid_i,
  input  wire logic [spq_pkg::UrgW-1:0]  left_urg_i,
  input  wire logic [LOC_W-1:0]          left_loc_i,
  input  wire logic [spq_pkg::KindW-1:0] left_kind_i,
  // Neighbor toward the back of the queue.
  input  wire logic                      right_valid_i,
  input  wire logic [spq_pkg::UrgW-1:0]  right_urg_i,
  input  wire logic [LOC_W-1:0]          right_loc_i,
  input  wire logic [spq_pkg::KindW-1:0] right_kind_i,
  // Own state, seen by both neighbors.
  output logic                           keep_o,
  output logic                           valid_o,
  output logic [spq_pkg::UrgW-1:0]       urg_o,
  output logic [LOC_W-1:0]               loc_o,
  output logic [spq_pkg::KindW-1:0]      kind_o
);
  import spq_pkg::*;

  logic              valid_q, valid_d;
  logic [UrgW-1:0]   urg_q, urg_d;
  logic [LOC_W-1:0]  loc_q, loc_d;
  logic [KindW-1:0]  kind_q, kind_d;

  // The cell keeps its entry on an insert when it ranks at or above the new one.
  assign keep_o = valid_q && (urg_q >= ctrl_i.urg);

  // Choose between holding, taking the new entry and shifting from a neighbor.
  always_comb begin
    valid_d = valid_q;
    urg_d   = urg_q;
    loc_d   = loc_q;
    kind_d  = kind_q;
    if (ctrl_i.ins) begin
      valid_d = valid_q | left_valid_i;
      if (!keep_o) begin
        if (left_keep_i) begin
          urg_d  = ctrl_i.urg;
          loc_d  = new_loc_i;
          kind_d = new_kind_i;
        end else begin
          urg_d  = left_urg_i;
          loc_d  = left_loc_i;
          kind_d = left_kind_i;
        end
      end
    end else if (ctrl_i.rem) begin
      valid_d = right_valid_i;
      urg_d   = right_urg_i;
      loc_d   = right_loc_i;
      kind_d  = right_kind_i;
    end
  end

  // Valid flag is control state and resets; the entry payload does not.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    urg_q  <= urg_d;
    loc_q  <= loc_d;
    kind_q <= kind_d;
  end

  assign valid_o = valid_q;
  assign urg_o   = urg_q;
  assign loc_o   = loc_q;
  assign kind_o  = kind_q;

endmodule
`default_nettype wire

FILE: rtl/stable_priority_queue.sv
// Latency: a result appears in the cycle after its input transfer.
// Throughput: one insert or remove per cycle while in_stall_o is low; the whole
// cell chain compares and shifts in parallel, and a one-entry output register
// decouples input and output handshakes.
// Reset: asynchronous, active low; empties the queue and drops any pending result.
`default_nettype none
module stable_priority_queue #(
  parameter int unsigned DEPTH         = 16,
  parameter int unsigned LOCATION_BITS = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic                         cmd_i,
  input  wire logic [spq_pkg::UrgW-1:0]     urgency_i,
  input  wire logic [spq_pkg::LocPortW-1:0] location_id_i,
  input  wire logic [spq_pkg::KindW-1:0]    request_kind_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [1:0]                        status_o,
  output logic [spq_pkg::UrgW-1:0]          urgency_out_o,
  output logic [spq_pkg::LocPortW-1:0]      location_out_o,
  output logic [spq_pkg::KindW-1:0]         kind_out_o,
  output logic [spq_pkg::OccW-1:0]          occupancy_o
);
  import spq_pkg::*;

  localparam int unsigned LocW = (LOCATION_BITS < LocPortW) ? LOCATION_BITS : LocPortW;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  spq_ctrl_t        ctrl;
  logic             in_xfer;
  logic             full, empty;
  logic [UrgW-1:0]  urg_clamped;
  logic [LocW-1:0]  new_loc;

  logic [CntW-1:0]  count_q, count_d;
  logic             out_valid_q, out_valid_d;
  spq_status_e      status_q, status_d;
  logic [UrgW-1:0]  urg_out_q, urg_out_d;
  logic [LocW-1:0]  loc_out_q, loc_out_d;
  logic [KindW-1:0] kind_out_q, kind_out_d;

  // Chain links, one slot per cell plus a terminating slot at the back.
  logic             keep  [DEPTH];
  logic             valid [DEPTH+1];
  logic [UrgW-1:0]  urg   [DEPTH+1];
  logic [LocW-1:0]  loc   [DEPTH+1];
  logic [KindW-1:0] kind  [DEPTH+1];

  // Input transfer is held off only while a result waits and is stalled.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_xfer    = in_valid_i && !in_stall_o;

  assign full  = valid[DEPTH-1];
  assign empty = !valid[0];

  // Clamp the urgency and trim the location tag before it enters the chain.
  always_comb begin
    urg_clamped = urgency_i;
    if (urgency_i < UrgMin) begin
      urg_clamped = UrgMin;
    end else if (urgency_i > UrgMax) begin
      urg_clamped = UrgMax;
    end
  end

  assign new_loc  = location_id_i[LocW-1:0];
  assign ctrl.ins = in_xfer && (cmd_i == CMD_INSERT) && !full;
  assign ctrl.rem = in_xfer && (cmd_i == CMD_REMOVE) && !empty;
  assign ctrl.urg = urg_clamped;

  // The back of the chain shifts in an empty slot on a remove.
  assign valid[DEPTH] = 1'b0;
  assign urg[DEPTH]   = '0;
  assign loc[DEPTH]   = '0;
  assign kind[DEPTH]  = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic             lk, lv;
    logic [UrgW-1:0]  lu;
    logic [LocW-1:0]  ll;
    logic [KindW-1:0] lkd;

    // The front cell sees a virtual neighbor that always keeps and is valid.
    if (i == 0) begin : g_front
      assign lk  = 1'b1;
      assign lv  = 1'b1;
      assign lu  = '0;
      assign ll  = '0;
      assign lkd = '0;
    end else begin : g_inner
      assign lk  = keep[i-1];
      assign lv  = valid[i-1];
      assign lu  = urg[i-1];
      assign ll  = loc[i-1];
      assign lkd = kind[i-1];
    end

    spq_cell #(
      .LOC_W(LocW)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .new_loc_i    (new_loc),
      .new_kind_i   (request_kind_i),
      .left_keep_i  (lk),
      .left_valid_i (lv),
      .left_urg_i   (lu),
      .left_loc_i   (ll),
      .left_kind_i  (lkd),
      .right_valid_i(valid[i+1]),
      .right_urg_i  (urg[i+1]),
      .right_loc_i  (loc[i+1]),
      .right_kind_i (kind[i+1]),
      .keep_o       (keep[i]),
      .valid_o      (valid[i]),
      .urg_o        (urg[i]),
      .loc_o        (loc[i]),
      .kind_o       (kind[i])
    );
  end

  // Occupancy counter and result formation.
  always_comb begin
    count_d     = count_q;
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    urg_out_d   = urg_out_q;
    loc_out_d   = loc_out_q;
    kind_out_d  = kind_out_q;
    if (ctrl.ins) begin
      count_d = count_q + 1'b1;
    end else if (ctrl.rem) begin
      count_d = count_q - 1'b1;
    end
    if (in_xfer) begin
      out_valid_d = 1'b1;
      urg_out_d   = '0;
      loc_out_d   = '0;
      kind_out_d  = '0;
      if (cmd_i == CMD_INSERT) begin
        status_d = full ? ST_FULL : ST_INSERTED;
      end else if (empty) begin
        status_d = ST_EMPTY;
      end else begin
        status_d   = ST_REMOVED;
        urg_out_d  = urg[0];
        loc_out_d  = loc[0];
        kind_out_d = kind[0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // The result payload is held in place while stalled.
  always_ff @(posedge clk_i) begin
    status_q   <= status_d;
    urg_out_q  <= urg_out_d;
    loc_out_q  <= loc_out_d;
    kind_out_q <= kind_out_d;
  end

  // Occupancy reflects the count after the step that produced the result.
  logic [CntW-1:0] occ_q;
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      occ_q <= count_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign urgency_out_o  = urg_out_q;
  assign location_out_o = LocPortW'(loc_out_q);
  assign kind_out_o     = kind_out_q;
  assign occupancy_o    = OccW'(occ_q);

endmodule
`default_nettype wire

FILE: rtl/spq_checker.sv
`default_nettype none
module spq_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_stall_o,
  input wire logic                         out_valid_o,
  input wire logic                         out_stall_i,
  input wire logic [1:0]                   status_o,
  input wire logic [spq_pkg::UrgW-1:0]     urgency_out_o,
  input wire logic [spq_pkg::LocPortW-1:0] location_out_o,
  input wire logic [spq_pkg::KindW-1:0]    kind_out_o,
  input wire logic [spq_pkg::OccW-1:0]     occupancy_o
);
  import spq_pkg::*;

  // A removed entry always carries a clamped urgency.
  a_removed_urgency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_REMOVED) |->
      (urgency_out_o >= UrgMin && urgency_out_o <= UrgMax))
    else $error("removed entry has an urgency outside the clamped range");

  // Results other than a removal carry all-zero entry fields.
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_REMOVED) |->
      (urgency_out_o == '0 && location_out_o == '0 && kind_out_o == '0))
    else $error("non-removal result carries entry data");

  // An empty report means nothing is stored.
  a_empty_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_EMPTY) |-> (occupancy_o == '0))
    else $error("empty report with nonzero occupancy");

  // The input stalls only while a result is waiting.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a pending stalled result");

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(status_o) && $stable(location_out_o)
       && $stable(occupancy_o)))
    else $error("stalled result changed");

endmodule

bind stable_priority_queue spq_checker u_spq_checker (.*);
`default_nettype wire
